// ===== src/ccsc_pkg.sv =====
// Shared types, constants and the CRC-32C byte update for the chunked CRC-32C stream checker.
// No dependencies; every other file imports this package.
`default_nettype none
package ccsc_pkg;

  localparam int OFF_W        = 40;  // stream offset width, offsets wrap at this width
  localparam int CHUNK_LEN_W  = 24;
  localparam int TOTAL_LEN_W  = 40;
  localparam int CHUNK_TOT_W  = CHUNK_LEN_W + 1;  // payload length plus checksum bytes
  localparam int CHECK_BYTES  = 4;
  localparam int CNT_W        = 3;
  localparam int STEP_W       = $clog2(TOTAL_LEN_W);
  localparam int CFG_IDX_W    = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;

  localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
  localparam logic [CHUNK_LEN_W-1:0] CHUNK_LEN_RST = CHUNK_LEN_W'(4096);
  localparam logic [TOTAL_LEN_W-1:0] TOTAL_LEN_RST = TOTAL_LEN_W'(1);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LEN = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_MATCH    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_HALTED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_CHECK      = 2'd1,
    KIND_CHECK_LAST = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } item_t;

  // Configuration view handed from the register block to the front end
  typedef struct packed {
    logic                   busy;
    logic                   cp_load;
    logic [CHUNK_LEN_W-1:0] chunk_len;
    logic [CHUNK_TOT_W-1:0] chunk_tot;
    logic                   tail_en;
    logic [OFF_W-1:0]       tail_start;
    logic [OFF_W-1:0]       tail_cp;
  } cfg_t;

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage
`default_nettype wire

// ===== src/ccsc_cfg.sv =====
// Configuration registers and the bit-serial remainder unit that sets up the tail chunk.
// Depends on ccsc_pkg.
`default_nettype none
module ccsc_cfg import ccsc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [CFG_IDX_W-1:0]   wr_index,
  input  wire logic [TOTAL_LEN_W-1:0] wr_data,
  output cfg_t                        cfg
);

  typedef enum logic [1:0] {DIV_IDLE, DIV_LOAD, DIV_RUN, DIV_DONE} div_state_t;

  div_state_t             state_r;
  logic [CHUNK_LEN_W-1:0] chunk_len_r;
  logic [TOTAL_LEN_W-1:0] total_len_r;
  logic [CHUNK_TOT_W-1:0] rem_r;
  logic [TOTAL_LEN_W-1:0] shift_r;
  logic [STEP_W-1:0]      step_r;
  logic                   tail_en_r;
  logic [OFF_W-1:0]       tail_start_r;
  logic [OFF_W-1:0]       tail_cp_r;
  logic                   cp_load_r;

  logic [CHUNK_TOT_W-1:0] chunk_tot;
  logic [CHUNK_TOT_W:0]   trial;
  logic [CHUNK_TOT_W:0]   trial_sub;
  logic [CHUNK_TOT_W-1:0] rem_nxt;

  assign chunk_tot = {1'b0, chunk_len_r} + CHUNK_TOT_W'(CHECK_BYTES);
  assign trial     = {rem_r, shift_r[TOTAL_LEN_W-1]};
  assign trial_sub = trial - {1'b0, chunk_tot};
  // Remainder always stays below the divisor, so it fits the narrower width
  assign rem_nxt   = (trial >= {1'b0, chunk_tot}) ? trial_sub[CHUNK_TOT_W-1:0]
                                                  : trial[CHUNK_TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= DIV_IDLE;
      chunk_len_r  <= CHUNK_LEN_RST;
      total_len_r  <= TOTAL_LEN_RST;
      rem_r        <= '0;
      shift_r      <= '0;
      step_r       <= '0;
      tail_en_r    <= 1'b0;
      tail_start_r <= '0;
      tail_cp_r    <= '0;
      cp_load_r    <= 1'b0;
    end else begin
      cp_load_r <= 1'b0;
      if (wr_en && (wr_index == REG_CHUNK_LEN || wr_index == REG_TOTAL_LEN)) begin
        if (wr_index == REG_CHUNK_LEN) begin
          chunk_len_r <= wr_data[CHUNK_LEN_W-1:0];
          cp_load_r   <= 1'b1;
        end else begin
          total_len_r <= wr_data;
        end
        state_r <= DIV_LOAD;
      end else begin
        unique case (state_r)
          DIV_IDLE: ;
          DIV_LOAD: begin
            rem_r   <= '0;
            shift_r <= total_len_r;
            step_r  <= STEP_W'(TOTAL_LEN_W - 1);
            state_r <= DIV_RUN;
          end
          DIV_RUN: begin
            rem_r   <= rem_nxt;
            shift_r <= {shift_r[TOTAL_LEN_W-2:0], 1'b0};
            step_r  <= step_r - STEP_W'(1);
            if (step_r == '0) state_r <= DIV_DONE;
          end
          DIV_DONE: begin
            tail_en_r    <= rem_r > CHUNK_TOT_W'(CHECK_BYTES);
            tail_start_r <= total_len_r - OFF_W'(rem_r);
            tail_cp_r    <= total_len_r - OFF_W'(CHECK_BYTES);
            state_r      <= DIV_IDLE;
          end
          default: state_r <= DIV_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    cfg.busy       = state_r != DIV_IDLE;
    cfg.cp_load    = cp_load_r;
    cfg.chunk_len  = chunk_len_r;
    cfg.chunk_tot  = chunk_tot;
    cfg.tail_en    = tail_en_r;
    cfg.tail_start = tail_start_r;
    cfg.tail_cp    = tail_cp_r;
  end

endmodule
`default_nettype wire

// ===== src/ccsc_front.sv =====
// Front end: accepts stream bytes, tracks the offset and checksum window, tags each byte.
// Depends on ccsc_pkg.
`default_nettype none
module ccsc_front import ccsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       q_ready,
  output logic            push,
  output item_t           push_item
);

  logic [OFF_W-1:0] off_r,  off_nxt;
  logic [OFF_W-1:0] cp_r,   cp_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;

  logic [OFF_W-1:0] diff;
  logic             in_win;
  logic             tail_hit;
  logic [OFF_W-1:0] cp_eff;
  logic             is_check;
  logic [CNT_W-1:0] cnt_inc;
  logic             is_last;

  assign in_ready = !cfg.busy && q_ready;
  assign push     = in_valid && in_ready;

  always_comb begin
    diff     = off_r - cp_r;
    in_win   = (off_r >= cp_r) && (diff <= OFF_W'(CHECK_BYTES));
    // Once inside the tail region, the next checksum sits just before the stream end
    tail_hit = !in_win && cfg.tail_en && (off_r >= cfg.tail_start);
    cp_eff   = tail_hit ? cfg.tail_cp : cp_r;
    is_check = in_win || (tail_hit && (off_r == cfg.tail_cp));
    cnt_inc  = cnt_r + CNT_W'(1);
    is_last  = is_check && (cnt_inc >= CNT_W'(CHECK_BYTES));

    off_nxt = off_r + OFF_W'(1);
    cp_nxt  = is_last ? (cp_eff + OFF_W'(cfg.chunk_tot)) : cp_eff;
    cnt_nxt = is_last ? '0 : (is_check ? cnt_inc : cnt_r);

    push_item.data = in_byte;
    priority if (is_last) push_item.kind = KIND_CHECK_LAST;
    else if (is_check)    push_item.kind = KIND_CHECK;
    else                  push_item.kind = KIND_PAYLOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      cp_r  <= OFF_W'(CHUNK_LEN_RST);
      cnt_r <= '0;
    end else if (cfg.cp_load) begin
      cp_r <= OFF_W'(cfg.chunk_len);
    end else if (push) begin
      off_r <= off_nxt;
      cp_r  <= cp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/ccsc_queue.sv =====
// Short queue of tagged bytes between the front end and the CRC back end.
// Depends on ccsc_pkg.
`default_nettype none
module ccsc_queue import ccsc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       push_ready,
  input  wire logic  pop,
  output item_t      pop_item,
  output logic       pop_valid
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/ccsc_back.sv =====
// Back end: running CRC-32C, checksum capture and compare, sticky halt, output register.
// Depends on ccsc_pkg.
`default_nettype none
module ccsc_back import ccsc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire item_t  q_item,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [7:0]  out_byte,
  output logic        out_payload,
  output status_t     out_status,
  output logic [31:0] out_computed,
  output logic [31:0] out_received
);

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        payload_r;
  status_t     status_r;
  logic [31:0] computed_r;
  logic [31:0] received_r;
  logic [31:0] crc_r;
  logic [31:0] shift_r;
  logic        halted_r;

  logic [31:0] shift_nxt;
  logic        match;

  assign pop       = q_valid && (!valid_r || out_ready);
  assign shift_nxt = {shift_r[23:0], q_item.data};
  assign match     = shift_nxt == crc_r;

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_payload  = payload_r;
  assign out_status   = status_r;
  assign out_computed = computed_r;
  assign out_received = received_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      crc_r    <= '0;
      shift_r  <= '0;
      halted_r <= 1'b0;
    end else if (pop) begin
      valid_r    <= 1'b1;
      byte_r     <= q_item.data;
      payload_r  <= 1'b0;
      status_r   <= ST_NONE;
      computed_r <= '0;
      received_r <= '0;
      if (halted_r) begin
        status_r <= ST_HALTED;
      end else begin
        unique case (q_item.kind)
          KIND_PAYLOAD: begin
            crc_r     <= crc32c_byte(crc_r, q_item.data);
            payload_r <= 1'b1;
          end
          KIND_CHECK: shift_r <= shift_nxt;
          KIND_CHECK_LAST: begin
            status_r   <= match ? ST_MATCH : ST_MISMATCH;
            computed_r <= crc_r;
            received_r <= shift_nxt;
            halted_r   <= !match;
            crc_r      <= '0;
            shift_r    <= '0;
          end
          default: ;
        endcase
      end
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/chunked_crc32c_stream_checker_core.sv =====
// Top level of the chunked CRC-32C stream checker: register block, front end, queue, back end.
// Depends on ccsc_pkg, ccsc_cfg, ccsc_front, ccsc_queue and ccsc_back.
//
//  Channel  | Handshake                 | Content
//  ---------+---------------------------+----------------------------------------------
//  in_      | in_tvalid / in_tready     | one stream byte per transaction
//  out_     | out_tvalid / out_tready   | one result per input byte, in order
//  cfg_     | cfg_valid / cfg_ready     | register write: 0 chunk length, 1 total length
//
// Sustained rate is one byte per cycle unless input is held off or output stalls; the CRC
// byte update and the window compares are combinational, and the four-entry queue plus
// output register absorb output stalls. A byte passes through the queue, then the output
// register. After reset the block is ready at once. A write to register 0 or 1 reruns the
// bit-serial remainder unit, holding input off for one load, 40 division steps and one setup; cfg_ready is always high.
`default_nettype none
module chunked_crc32c_stream_checker_core import ccsc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] in_byte
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [71:0]                 out_tdata,  // [7:0] out_byte, [39:8] computed_crc,
                                                  // [71:40] received_crc
  output logic [2:0]                  out_tuser,  // [0] is_payload, [2:1] check_status
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [TOTAL_LEN_W-1:0] cfg_data
);

  cfg_t        cfg;
  item_t       push_item;
  item_t       pop_item;
  logic        push;
  logic        q_ready;
  logic        pop;
  logic        q_valid;
  logic [7:0]  res_byte;
  logic        res_payload;
  status_t     res_status;
  logic [31:0] res_computed;
  logic [31:0] res_received;

  assign cfg_ready = 1'b1;

  ccsc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ccsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .q_ready   (q_ready),
    .push      (push),
    .push_item (push_item)
  );

  ccsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_item   (pop_item),
    .pop_valid  (q_valid)
  );

  ccsc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (pop_item),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (res_byte),
    .out_payload  (res_payload),
    .out_status   (res_status),
    .out_computed (res_computed),
    .out_received (res_received)
  );

  assign out_tdata = {res_received, res_computed, res_byte};
  assign out_tuser = {res_status, res_payload};

endmodule
`default_nettype wire

// ===== src/ccsc_checker.sv =====
// Port-level checker for the chunked CRC-32C stream checker, bound to the top level.
// Depends on ccsc_pkg and chunked_crc32c_stream_checker_core.
`default_nettype none
module ccsc_checker import ccsc_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [71:0]            out_tdata,
  input wire logic [2:0]             out_tuser,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready,
  input wire logic [CFG_IDX_W-1:0]   cfg_index
);

  logic    halt_seen_r;
  status_t status;
  logic    len_write;

  assign status    = status_t'(out_tuser[2:1]);
  assign len_write = cfg_valid && cfg_ready &&
                     (cfg_index == REG_CHUNK_LEN || cfg_index == REG_TOTAL_LEN);

  // Remember a delivered mismatch; every later result must then report halted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready && status == ST_MISMATCH) begin
      halt_seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && halt_seen_r |-> status == ST_HALTED && !out_tuser[0])
    else $error("result after a mismatch is not halted");

  a_match_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == ST_MATCH |-> out_tdata[39:8] == out_tdata[71:40])
    else $error("match reported with differing checksums");

  a_no_crc_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == ST_NONE || status == ST_HALTED) |-> out_tdata[71:8] == '0)
    else $error("checksum fields set without a check result");

  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    len_write |=> !in_tready)
    else $error("input taken while tail setup is running");

endmodule

bind chunked_crc32c_stream_checker_core ccsc_checker u_ccsc_checker (.*);
`default_nettype wire
